/* rtl/ght_pkg.sv */
`default_nettype none
package ght_pkg;

  // Table geometry.
  localparam int SLOTS        = 128;
  localparam int GEN_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);

  // Operation codes carried by the op field.
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_NULL    = 2'd3
  } status_t;

  // Controller sequence states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_EXEC = 2'd2
  } state_t;

  // One slot memory word.
  typedef struct packed {
    logic [GEN_BITS-1:0]     gen;
    logic                    busy;
    logic [PAYLOAD_BITS-1:0] payload;
  } slot_entry_t;

  localparam int SLOT_W = $bits(slot_entry_t);

endpackage
`default_nettype wire

/* rtl/ght_if.sv */
`default_nettype none
// Request channel.
interface ght_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic [ght_pkg::IDX_W-1:0]        handle_index;
  logic [ght_pkg::GEN_BITS-1:0]     handle_generation;
  logic [ght_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, op, handle_index, handle_generation, payload,
                  input ready);
  modport sink   (input valid, op, handle_index, handle_generation, payload,
                  output ready);
endinterface

// Result channel.
interface ght_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [ght_pkg::IDX_W-1:0]        out_index;
  logic [ght_pkg::GEN_BITS-1:0]     out_generation;
  logic [ght_pkg::PAYLOAD_BITS-1:0] payload_out;
  logic [ght_pkg::CNT_W-1:0]        live_count;

  modport source (output valid, status, out_index, out_generation, payload_out,
                  live_count, input ready);
  modport sink   (input valid, status, out_index, out_generation, payload_out,
                  live_count, output ready);
endinterface
`default_nettype wire

/* rtl/generational_handle_slot_table.sv */
`default_nettype none
// Generational handle table of 128 slots. Each request is an allocate, free
// or lookup and yields exactly one result carrying a status, the new handle
// on allocate, the stored payload on lookup and the live slot count. Slot
// state and the free stack sit in two synchronous RAMs; a request goes from
// transfer through the execute state to the result register (through the
// pop state first for an allocate that reuses a freed slot, whose stack pop
// must be read before the slot word), as both RAMs register read data. One
// request is in flight at a time; the result register holds a finished
// result while the next request is taken. No clearing pass is needed
// after reset: slots at or above the high-water mark read as free, generation 0.
module generational_handle_slot_table (
  input  wire logic clk,
  input  wire logic rst_n,
  ght_in_if.sink    in_chan,
  ght_out_if.source out_chan
);

  logic                      sl_we;
  logic [ght_pkg::IDX_W-1:0] sl_waddr;
  ght_pkg::slot_entry_t      sl_wdata;
  logic [ght_pkg::IDX_W-1:0] sl_raddr;
  ght_pkg::slot_entry_t      sl_rdata;
  logic                      stk_we;
  logic [ght_pkg::IDX_W-1:0] stk_waddr;
  logic [ght_pkg::IDX_W-1:0] stk_wdata;
  logic [ght_pkg::IDX_W-1:0] stk_raddr;
  logic [ght_pkg::IDX_W-1:0] stk_rdata;

  // Sequencer.
  ght_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .sl_we     (sl_we),
    .sl_waddr  (sl_waddr),
    .sl_wdata  (sl_wdata),
    .sl_raddr  (sl_raddr),
    .sl_rdata  (sl_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // Slot words: generation, in-use bit and payload.
  ght_ram #(
    .DATA_W (ght_pkg::SLOT_W),
    .ADDR_W (ght_pkg::IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  // Free stack of released indices.
  ght_ram #(
    .DATA_W (ght_pkg::IDX_W),
    .ADDR_W (ght_pkg::IDX_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

endmodule
`default_nettype wire

/* rtl/ght_ram.sv */
`default_nettype none
// Simple dual-port synchronous RAM, registered read data.
module ght_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/ght_ctrl.sv */
`default_nettype none
// Operation sequencer: reads the free stack and slot memories, decides the
// result, writes the memories back and holds the result register.
module ght_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  ght_in_if.sink                        in_chan,
  ght_out_if.source                     out_chan,
  // Slot memory.
  output logic                          sl_we,
  output logic [ght_pkg::IDX_W-1:0]     sl_waddr,
  output ght_pkg::slot_entry_t          sl_wdata,
  output logic [ght_pkg::IDX_W-1:0]     sl_raddr,
  input  wire ght_pkg::slot_entry_t     sl_rdata,
  // Free stack memory.
  output logic                          stk_we,
  output logic [ght_pkg::IDX_W-1:0]     stk_waddr,
  output logic [ght_pkg::IDX_W-1:0]     stk_wdata,
  output logic [ght_pkg::IDX_W-1:0]     stk_raddr,
  input  wire logic [ght_pkg::IDX_W-1:0] stk_rdata
);

  ght_pkg::state_t                  state_r, state_nxt;
  logic [1:0]                       op_r;
  logic [ght_pkg::GEN_BITS-1:0]     hgen_r;
  logic [ght_pkg::PAYLOAD_BITS-1:0] pay_r;
  logic [ght_pkg::IDX_W-1:0]        slot_r, slot_nxt;
  logic [ght_pkg::CNT_W-1:0]        fd_r, fd_nxt;
  logic [ght_pkg::CNT_W-1:0]        hw_r, hw_nxt;
  logic [ght_pkg::CNT_W-1:0]        busy_r, busy_nxt;

  logic                             out_valid_r;
  logic [1:0]                       status_r, status_nxt;
  logic [ght_pkg::IDX_W-1:0]        oidx_r, oidx_nxt;
  logic [ght_pkg::GEN_BITS-1:0]     ogen_r, ogen_nxt;
  logic [ght_pkg::PAYLOAD_BITS-1:0] opay_r, opay_nxt;

  logic                             accept;
  logic                             commit;
  logic                             in_range;
  logic                             handle_ok;
  logic                             table_full;
  logic                             from_stack;
  logic [ght_pkg::GEN_BITS-1:0]     gen_old;
  logic [ght_pkg::GEN_BITS-1:0]     gen_inc;
  logic [ght_pkg::GEN_BITS-1:0]     gen_new;

  assign accept = in_chan.valid && in_chan.ready;
  assign commit = (state_r == ght_pkg::S_EXEC) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready = (state_r == ght_pkg::S_IDLE);

  // Checks on the slot word returned for slot_r. Entries at or above the
  // high-water mark were never written and read as generation zero, not busy.
  assign in_range   = ({1'b0, slot_r} < hw_r);
  assign handle_ok  = (hgen_r != '0) && in_range && sl_rdata.busy &&
                      (sl_rdata.gen == hgen_r);
  assign table_full = (fd_r == '0) && (hw_r >= ght_pkg::CNT_W'(ght_pkg::SLOTS));
  assign from_stack = (fd_r != '0);
  assign gen_old    = in_range ? sl_rdata.gen : '0;
  assign gen_inc    = gen_old + ght_pkg::GEN_BITS'(1);
  assign gen_new    = (gen_inc == '0) ? ght_pkg::GEN_BITS'(1) : gen_inc;

  // Memory read addresses.
  assign stk_raddr = ght_pkg::IDX_W'(fd_r - ght_pkg::CNT_W'(1));
  always_comb begin
    case (state_r)
      ght_pkg::S_IDLE: begin
        sl_raddr = (in_chan.op == ght_pkg::OP_ALLOC) ? ght_pkg::IDX_W'(hw_r)
                                                     : in_chan.handle_index;
      end
      ght_pkg::S_POP:  sl_raddr = stk_rdata;
      default:         sl_raddr = slot_r;
    endcase
  end

  // Sequencing, result decision and write-back.
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    fd_nxt     = fd_r;
    hw_nxt     = hw_r;
    busy_nxt   = busy_r;
    status_nxt = status_r;
    oidx_nxt   = oidx_r;
    ogen_nxt   = ogen_r;
    opay_nxt   = opay_r;
    sl_we      = 1'b0;
    sl_waddr   = slot_r;
    sl_wdata   = sl_rdata;
    stk_we     = 1'b0;
    stk_waddr  = ght_pkg::IDX_W'(fd_r);
    stk_wdata  = slot_r;

    case (state_r)
      ght_pkg::S_IDLE: begin
        if (accept) begin
          slot_nxt = sl_raddr;
          if ((in_chan.op == ght_pkg::OP_ALLOC) && (in_chan.payload != '0) &&
              from_stack) begin
            state_nxt = ght_pkg::S_POP;
          end else begin
            state_nxt = ght_pkg::S_EXEC;
          end
        end
      end
      ght_pkg::S_POP: begin
        slot_nxt  = stk_rdata;
        state_nxt = ght_pkg::S_EXEC;
      end
      ght_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt  = ght_pkg::S_IDLE;
          status_nxt = ght_pkg::ST_INVALID;
          oidx_nxt   = '0;
          ogen_nxt   = '0;
          opay_nxt   = '0;
          case (op_r)
            ght_pkg::OP_ALLOC: begin
              if (pay_r == '0) begin
                status_nxt = ght_pkg::ST_NULL;
              end else if (table_full) begin
                status_nxt = ght_pkg::ST_FULL;
              end else begin
                if (from_stack) begin
                  fd_nxt = fd_r - ght_pkg::CNT_W'(1);
                end else begin
                  hw_nxt = hw_r + ght_pkg::CNT_W'(1);
                end
                sl_we            = 1'b1;
                sl_wdata.gen     = gen_new;
                sl_wdata.busy    = 1'b1;
                sl_wdata.payload = pay_r;
                busy_nxt         = busy_r + ght_pkg::CNT_W'(1);
                status_nxt       = ght_pkg::ST_OK;
                oidx_nxt         = slot_r;
                ogen_nxt         = gen_new;
              end
            end
            ght_pkg::OP_FREE: begin
              if (handle_ok && (fd_r < ght_pkg::CNT_W'(ght_pkg::SLOTS))) begin
                sl_we            = 1'b1;
                sl_wdata.gen     = sl_rdata.gen;
                sl_wdata.busy    = 1'b0;
                sl_wdata.payload = '0;
                stk_we           = 1'b1;
                fd_nxt           = fd_r + ght_pkg::CNT_W'(1);
                if (busy_r != '0) begin
                  busy_nxt = busy_r - ght_pkg::CNT_W'(1);
                end
                status_nxt = ght_pkg::ST_OK;
              end
            end
            ght_pkg::OP_LOOKUP: begin
              if (handle_ok) begin
                status_nxt = ght_pkg::ST_OK;
                opay_nxt   = sl_rdata.payload;
              end
            end
            default: begin
              status_nxt = ght_pkg::ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ght_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ght_pkg::S_IDLE;
      fd_r        <= '0;
      hw_r        <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fd_r    <= fd_nxt;
      hw_r    <= hw_nxt;
      busy_r  <= busy_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.op;
      hgen_r <= in_chan.handle_generation;
      pay_r  <= in_chan.payload;
    end
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    oidx_r   <= oidx_nxt;
    ogen_r   <= ogen_nxt;
    opay_r   <= opay_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = status_r;
  assign out_chan.out_index      = oidx_r;
  assign out_chan.out_generation = ogen_r;
  assign out_chan.payload_out    = opay_r;
  assign out_chan.live_count     = busy_r;

  // Every index below the high-water mark is either in use or on the free stack.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fd_r} + {1'b0, busy_r}) == {1'b0, hw_r})
    else $error("free stack depth plus live count differs from high-water mark");

  // The high-water mark never moves back.
  a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> hw_r >= $past(hw_r))
    else $error("high-water mark decreased");

  // A committed operation always presents a result in the next cycle.
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("result register not loaded after commit");

  // Memories are only written when an operation commits.
  a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (sl_we || stk_we) |-> commit)
    else $error("memory written outside a commit");

endmodule
`default_nettype wire
